/* src/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants for the curtain frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

	localparam logic [15:0] SEED_RESET = 16'h2017;
	localparam logic [7:0]  HDR_A      = 8'h55;
	localparam logic [7:0]  HDR_B      = 8'hAA;

	typedef logic [4:0] cfp_phase_t;

	localparam cfp_phase_t PH_HUNT     = 5'd0;
	localparam cfp_phase_t PH_HDR1     = 5'd1;
	localparam cfp_phase_t PH_HDR2     = 5'd2;
	localparam cfp_phase_t PH_HDR3     = 5'd3;
	localparam cfp_phase_t PH_SUM_LO   = 5'd4;
	localparam cfp_phase_t PH_SUM_HI   = 5'd5;
	localparam cfp_phase_t PH_CMD_LO   = 5'd6;
	localparam cfp_phase_t PH_CMD_HI   = 5'd7;
	localparam cfp_phase_t PH_LEN_LO   = 5'd8;
	localparam cfp_phase_t PH_LEN_HI   = 5'd9;
	localparam cfp_phase_t PH_ACTION   = 5'd13;
	localparam cfp_phase_t PH_POSITION = 5'd14;
	localparam cfp_phase_t PH_LAST     = 5'd21;

	localparam logic REG_SEED = 1'b0;

	typedef struct packed {
		logic        valid;
		logic [15:0] command_id;
		logic [15:0] payload_length;
		logic [7:0]  action_code;
		logic [7:0]  position_byte;
		logic        checksum_good;
	} cfp_result_t;

endpackage

/* src/cfp_parser.sv */
// ----------------------------------------------------------------------------
// cfp_parser
// Frame state, running checksum and field capture; one byte per beat.
// ----------------------------------------------------------------------------
module cfp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_buffer,
	input  logic [15:0]          seed,
	output cfp_pkg::cfp_result_t result
);

	cfp_pkg::cfp_phase_t phase_q, phase_d;
	logic [15:0] running_sum_q, running_sum_d;
	logic [15:0] received_sum_q, received_sum_d;
	logic [15:0] command_word_q, command_word_d;
	logic [15:0] length_word_q, length_word_d;
	logic [7:0]  action_hold_q, action_hold_d;
	logic [7:0]  position_hold_q, position_hold_d;

	logic [15:0]         sum_add;
	logic [15:0]         hunt_sum;
	cfp_pkg::cfp_phase_t hunt_phase;
	logic                in_body;
	logic                good;

	assign sum_add    = running_sum_q + {8'h00, data_byte};
	assign hunt_sum   = (data_byte == cfp_pkg::HDR_A) ? seed + {8'h00, cfp_pkg::HDR_A} : seed;
	assign hunt_phase = (data_byte == cfp_pkg::HDR_A) ? cfp_pkg::PH_HDR1 : cfp_pkg::PH_HUNT;
	assign in_body    = (phase_q >= cfp_pkg::PH_CMD_LO) && (phase_q <= cfp_pkg::PH_LAST);
	assign good       = (sum_add == received_sum_q);

	always_comb begin
		phase_d         = phase_q;
		running_sum_d   = running_sum_q;
		received_sum_d  = received_sum_q;
		command_word_d  = command_word_q;
		length_word_d   = length_word_q;
		action_hold_d   = action_hold_q;
		position_hold_d = position_hold_q;
		case (phase_q)
			cfp_pkg::PH_HDR1, cfp_pkg::PH_HDR2: begin
				if (data_byte == cfp_pkg::HDR_B) begin
					running_sum_d = sum_add;
					phase_d       = phase_q + 5'd1;
				end else begin
					running_sum_d = hunt_sum;
					phase_d       = hunt_phase;
				end
			end
			cfp_pkg::PH_HDR3: begin
				if (data_byte == cfp_pkg::HDR_A) begin
					running_sum_d = sum_add;
					phase_d       = cfp_pkg::PH_SUM_LO;
				end else begin
					running_sum_d = hunt_sum;
					phase_d       = hunt_phase;
				end
			end
			cfp_pkg::PH_SUM_LO: begin
				received_sum_d = {8'h00, data_byte};
				phase_d        = cfp_pkg::PH_SUM_HI;
			end
			cfp_pkg::PH_SUM_HI: begin
				received_sum_d = {data_byte, received_sum_q[7:0]};
				phase_d        = cfp_pkg::PH_CMD_LO;
			end
			default: begin
				if (in_body) begin
					running_sum_d = sum_add;
					if (phase_q == cfp_pkg::PH_CMD_LO)   command_word_d = {8'h00, data_byte};
					if (phase_q == cfp_pkg::PH_CMD_HI)   command_word_d = {data_byte, command_word_q[7:0]};
					if (phase_q == cfp_pkg::PH_LEN_LO)   length_word_d  = {8'h00, data_byte};
					if (phase_q == cfp_pkg::PH_LEN_HI)   length_word_d  = {data_byte, length_word_q[7:0]};
					if (phase_q == cfp_pkg::PH_ACTION)   action_hold_d  = data_byte;
					if (phase_q == cfp_pkg::PH_POSITION) position_hold_d = data_byte;
					if (phase_q == cfp_pkg::PH_LAST) begin
						phase_d       = cfp_pkg::PH_HUNT;
						running_sum_d = seed;
					end else begin
						phase_d = phase_q + 5'd1;
					end
				end else begin
					running_sum_d = hunt_sum;
					phase_d       = hunt_phase;
				end
			end
		endcase
		if (end_of_buffer) begin
			phase_d       = cfp_pkg::PH_HUNT;
			running_sum_d = seed;
		end
	end

	always_comb begin
		result.valid          = (phase_q == cfp_pkg::PH_LAST);
		result.command_id     = good ? command_word_q : 16'h0000;
		result.payload_length = length_word_q;
		result.action_code    = action_hold_q;
		result.position_byte  = position_hold_q;
		result.checksum_good  = good;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= cfp_pkg::PH_HUNT;
			running_sum_q   <= cfp_pkg::SEED_RESET;
			received_sum_q  <= 16'h0000;
			command_word_q  <= 16'h0000;
			length_word_q   <= 16'h0000;
			action_hold_q   <= 8'h00;
			position_hold_q <= 8'h00;
		end else if (advance) begin
			phase_q         <= phase_d;
			running_sum_q   <= running_sum_d;
			received_sum_q  <= received_sum_d;
			command_word_q  <= command_word_d;
			length_word_q   <= length_word_d;
			action_hold_q   <= action_hold_d;
			position_hold_q <= position_hold_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= cfp_pkg::PH_LAST)
		else $error("phase out of range");

	a_eob_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && end_of_buffer |=> phase_q == cfp_pkg::PH_HUNT)
		else $error("end of buffer did not return to hunting");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == cfp_pkg::PH_LAST |=> phase_q == cfp_pkg::PH_HUNT)
		else $error("frame end did not return to hunting");
`endif

endmodule

/* src/curtain_frame_parser_core.sv */
// ----------------------------------------------------------------------------
// curtain_frame_parser_core
// Curtain motor frame parser: header hunt, field capture, checksum check.
// ----------------------------------------------------------------------------
// Channel   Signals                                        Direction
// bytes     byte_valid/byte_ready, data_byte, end_of_buffer  in
// frames    frame_valid/frame_ready, command_id, payload_length,
//           action_code, position_byte, checksum_good      out
// config    psel/penable/pwrite/paddr/pwdata/prdata/pready  APB
//
// One byte per cycle; a frame beat appears the cycle after its last byte.
// Byte acceptance is held off only while a frame beat waits and frame_ready
// is low; the output register frees up on the same edge it is taken.
// Reset clears the parser to hunting and the seed to 0x2017.
// ----------------------------------------------------------------------------
module curtain_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        frame_valid,
	input  logic        frame_ready,
	output logic [15:0] command_id,
	output logic [15:0] payload_length,
	output logic [7:0]  action_code,
	output logic [7:0]  position_byte,
	output logic        checksum_good,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                 seed_wr;
	logic [15:0]          seed_q;
	logic                 advance;
	cfp_pkg::cfp_result_t result;
	logic                 frame_valid_q;
	logic [15:0]          command_id_q;
	logic [15:0]          payload_length_q;
	logic [7:0]           action_code_q;
	logic [7:0]           position_byte_q;
	logic                 checksum_good_q;

	assign pready  = 1'b1;
	assign seed_wr = psel && penable && pwrite && (paddr[2] == cfp_pkg::REG_SEED);
	assign prdata  = (paddr[2] == cfp_pkg::REG_SEED) ? {16'h0000, seed_q} : 32'h0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= cfp_pkg::SEED_RESET;
		end else if (seed_wr) begin
			seed_q <= pwdata[15:0];
		end
	end

	assign byte_ready = !frame_valid_q || frame_ready;
	assign advance    = byte_valid && byte_ready;

	cfp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.seed          (seed_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (advance) begin
			frame_valid_q <= result.valid;
		end else if (frame_ready) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			command_id_q     <= result.command_id;
			payload_length_q <= result.payload_length;
			action_code_q    <= result.action_code;
			position_byte_q  <= result.position_byte;
			checksum_good_q  <= result.checksum_good;
		end
	end

	assign frame_valid    = frame_valid_q;
	assign command_id     = command_id_q;
	assign payload_length = payload_length_q;
	assign action_code    = action_code_q;
	assign position_byte  = position_byte_q;
	assign checksum_good  = checksum_good_q;

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_valid |-> byte_ready)
		else $error("byte channel stalled with empty output register");

	a_bad_sum_zero_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !checksum_good |-> command_id == 16'h0000)
		else $error("command not cleared on checksum mismatch");

	a_no_frame_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance && !frame_valid |=> !frame_valid)
		else $error("frame beat appeared without a byte");
`endif

endmodule
